// ----- src/asp_pkg.sv -----
package asp_pkg;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_SPS   = 2'd1,
    OP_PPS   = 2'd2,
    OP_NONE  = 2'd3
  } asp_op_e;

  // Source of an output beat
  typedef enum logic [1:0] {
    SRC_CONST = 2'd0,
    SRC_SPS   = 2'd1,
    SRC_PPS   = 2'd2,
    SRC_MARK  = 2'd3
  } asp_src_e;

  localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
  localparam logic [7:0] NAL_TYPE_IDR  = 8'h05;
  localparam logic [7:0] SC_ZERO       = 8'h00;
  localparam logic [7:0] SC_ONE        = 8'h01;
  localparam int unsigned MinTableLen  = 4;
  localparam int unsigned StartCodeLen = 4;

  // Emission plan for one frame byte, handed from scanner to sequencer
  typedef struct packed {
    logic       idr;   // SPS/PPS insertion ahead of the unit
    logic       hdr;   // fresh start code ahead of the unit
    logic [2:0] nz;    // held zeros to release
    logic       eb;    // emit the carried byte
    logic [7:0] byt;   // the carried byte
    logic       last;  // frame ends with this byte
  } asp_plan_t;

endpackage

// ----- src/asp_ram.sv -----
module asp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port that holds without re_i
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/asp_scan.sv -----
module asp_scan
  import asp_pkg::*;
#(
  parameter int unsigned SPS_DEPTH = 32,
  parameter int unsigned PPS_DEPTH = 16,
  localparam int unsigned SpsLenW  = $clog2(SPS_DEPTH + 1),
  localparam int unsigned PpsLenW  = $clog2(PPS_DEPTH + 1),
  localparam int unsigned SpsAddrW = $clog2(SPS_DEPTH),
  localparam int unsigned PpsAddrW = $clog2(PPS_DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_fire_i,
  input  logic [1:0]          op_i,
  input  logic [7:0]          data_i,
  input  logic                last_i,
  output logic                sps_we_o,
  output logic [SpsAddrW-1:0] sps_waddr_o,
  output logic                pps_we_o,
  output logic [PpsAddrW-1:0] pps_waddr_o,
  output logic [7:0]          wdata_o,
  output logic [SpsLenW-1:0]  sps_len_o,
  output logic [PpsLenW-1:0]  pps_len_o,
  output logic                plan_valid_o,
  output asp_plan_t           plan_o
);

  logic [SpsLenW-1:0] sps_len_q, sps_len_d, sps_len_eff;
  logic [PpsLenW-1:0] pps_len_q, pps_len_d, pps_len_eff;
  logic [1:0]         ovf_q, ovf_d;
  logic [1:0]         lip_q, lip_d;
  logic [1:0]         pz_q, pz_d;
  logic               iu_q, iu_d;
  logic               hp_q, hp_d;
  logic               tables_ok;
  logic               sps_room, pps_room;
  asp_plan_t          plan;

  // table load: first beat of a load restarts the table
  assign sps_len_eff = lip_q[0] ? sps_len_q : '0;
  assign pps_len_eff = lip_q[1] ? pps_len_q : '0;
  assign sps_room    = sps_len_eff < SpsLenW'(SPS_DEPTH);
  assign pps_room    = pps_len_eff < PpsLenW'(PPS_DEPTH);

  assign sps_we_o    = in_fire_i && (op_i == OP_SPS) && sps_room;
  assign pps_we_o    = in_fire_i && (op_i == OP_PPS) && pps_room;
  assign sps_waddr_o = sps_len_eff[SpsAddrW-1:0];
  assign pps_waddr_o = pps_len_eff[PpsAddrW-1:0];
  assign wdata_o     = data_i;

  assign tables_ok = (sps_len_q >= SpsLenW'(MinTableLen)) &&
                     (pps_len_q >= PpsLenW'(MinTableLen)) && (ovf_q == 2'b00);

  // scan state and emission plan
  always_comb begin
    sps_len_d = sps_len_q;
    pps_len_d = pps_len_q;
    ovf_d     = ovf_q;
    lip_d     = lip_q;
    pz_d      = pz_q;
    iu_d      = iu_q;
    hp_d      = hp_q;
    plan      = '0;
    plan.byt  = data_i;
    plan.last = last_i;

    case (op_i)
      OP_SPS: begin
        lip_d[0] = 1'b1;
        if (!lip_q[0]) begin
          ovf_d[0] = 1'b0;
        end
        if (sps_room) begin
          sps_len_d = sps_len_eff + SpsLenW'(1);
        end else begin
          sps_len_d = sps_len_eff;
          ovf_d[0]  = 1'b1;
        end
        if (last_i) begin
          lip_d[0] = 1'b0;
        end
      end
      OP_PPS: begin
        lip_d[1] = 1'b1;
        if (!lip_q[1]) begin
          ovf_d[1] = 1'b0;
        end
        if (pps_room) begin
          pps_len_d = pps_len_eff + PpsLenW'(1);
        end else begin
          pps_len_d = pps_len_eff;
          ovf_d[1]  = 1'b1;
        end
        if (last_i) begin
          lip_d[1] = 1'b0;
        end
      end
      OP_FRAME: begin
        if ((pz_q == 2'd3) && (data_i == SC_ONE)) begin
          // start code completed
          pz_d = 2'd0;
          iu_d = 1'b1;
          hp_d = 1'b1;
        end else if (hp_q) begin
          // first byte of a unit
          hp_d     = 1'b0;
          plan.hdr = 1'b1;
          plan.idr = (data_i & NAL_TYPE_MASK) == NAL_TYPE_IDR;
          plan.eb  = (data_i != SC_ZERO) || last_i;
          pz_d     = (data_i == SC_ZERO) ? 2'd1 : 2'd0;
        end else if (data_i == SC_ZERO) begin
          if (pz_q != 2'd3) begin
            pz_d = pz_q + 2'd1;
            if (last_i && iu_q) begin
              plan.nz = {1'b0, pz_q} + 3'd1;
            end
          end else if (iu_q) begin
            // fourth zero and beyond passes through; frame end adds the held three
            plan.nz = last_i ? 3'd4 : 3'd1;
          end
        end else begin
          if (iu_q) begin
            plan.nz = {1'b0, pz_q};
            plan.eb = 1'b1;
          end
          pz_d = 2'd0;
        end
        if (last_i) begin
          pz_d = 2'd0;
          iu_d = 1'b0;
          hp_d = 1'b0;
        end
        if (!tables_ok) begin
          plan.idr = 1'b0;
          plan.hdr = 1'b0;
          plan.nz  = 3'd0;
          plan.eb  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sps_len_q <= '0;
      pps_len_q <= '0;
      ovf_q     <= 2'b00;
      lip_q     <= 2'b00;
      pz_q      <= 2'd0;
      iu_q      <= 1'b0;
      hp_q      <= 1'b0;
    end else if (in_fire_i) begin
      sps_len_q <= sps_len_d;
      pps_len_q <= pps_len_d;
      ovf_q     <= ovf_d;
      lip_q     <= lip_d;
      pz_q      <= pz_d;
      iu_q      <= iu_d;
      hp_q      <= hp_d;
    end
  end

  assign sps_len_o    = sps_len_q;
  assign pps_len_o    = pps_len_q;
  assign plan_valid_o = in_fire_i && (op_i == OP_FRAME);
  assign plan_o       = plan;

endmodule

// ----- src/asp_seq.sv -----
module asp_seq
  import asp_pkg::*;
#(
  parameter int unsigned SPS_DEPTH = 32,
  parameter int unsigned PPS_DEPTH = 16,
  localparam int unsigned SpsLenW  = $clog2(SPS_DEPTH + 1),
  localparam int unsigned PpsLenW  = $clog2(PPS_DEPTH + 1),
  localparam int unsigned SpsAddrW = $clog2(SPS_DEPTH),
  localparam int unsigned PpsAddrW = $clog2(PPS_DEPTH),
  localparam int unsigned CntW     = (SpsLenW > PpsLenW) ? SpsLenW : PpsLenW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                plan_valid_i,
  input  asp_plan_t           plan_i,
  input  logic [SpsLenW-1:0]  sps_len_i,
  input  logic [PpsLenW-1:0]  pps_len_i,
  input  logic [7:0]          sps_rdata_i,
  input  logic [7:0]          pps_rdata_i,
  output logic                in_ready_o,
  output logic                sps_re_o,
  output logic [SpsAddrW-1:0] sps_raddr_o,
  output logic                pps_re_o,
  output logic [PpsAddrW-1:0] pps_raddr_o,
  output logic [7:0]          data_res_o,
  output logic                data_valid_o,
  output logic                run_last_o,
  output logic                frame_end_o,
  output logic                out_valid_o,
  input  logic                out_ready_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SC1,
    S_SPS,
    S_SC2,
    S_PPS,
    S_SC3,
    S_ZERO,
    S_BYTE,
    S_MARK
  } state_e;

  state_e      state_q, state_next, state_entry;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] phase_len;
  logic        phase_end;
  logic        adv;
  asp_plan_t   plan_q;
  logic        tok_valid_q;
  asp_src_e    tok_src_q;
  logic [7:0]  tok_byte_q;
  logic        tok_last_q;
  logic        tok_fe_q;
  logic [7:0]  sc_byte;

  // output stage takes a new beat when empty or being drained
  assign adv = !tok_valid_q || out_ready_i;

  // length of the current phase, and the shared end compare
  always_comb begin
    case (state_q)
      S_SC1, S_SC2, S_SC3: phase_len = CntW'(StartCodeLen);
      S_SPS:               phase_len = CntW'(sps_len_i);
      S_PPS:               phase_len = CntW'(pps_len_i);
      S_ZERO:              phase_len = CntW'(plan_q.nz);
      default:             phase_len = CntW'(1);
    endcase
  end
  assign phase_end = cnt_q == (phase_len - CntW'(1));

  // next non-empty phase
  always_comb begin
    case (state_q)
      S_SC1:   state_next = S_SPS;
      S_SPS:   state_next = S_SC2;
      S_SC2:   state_next = S_PPS;
      S_PPS:   state_next = S_SC3;
      S_SC3:   state_next = (plan_q.nz != 3'd0) ? S_ZERO : (plan_q.eb ? S_BYTE : S_IDLE);
      S_ZERO:  state_next = plan_q.eb ? S_BYTE : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // first phase of a new plan
  always_comb begin
    if (plan_i.idr) begin
      state_entry = S_SC1;
    end else if (plan_i.hdr) begin
      state_entry = S_SC3;
    end else if (plan_i.nz != 3'd0) begin
      state_entry = S_ZERO;
    end else if (plan_i.eb) begin
      state_entry = S_BYTE;
    end else if (plan_i.last) begin
      state_entry = S_MARK;
    end else begin
      state_entry = S_IDLE;
    end
  end

  assign sc_byte = (cnt_q[1:0] == 2'd3) ? SC_ONE : SC_ZERO;

  // table reads issued as the beat is loaded into the output stage, so the data arrives with it
  assign sps_re_o    = adv && (state_q == S_SPS);
  assign pps_re_o    = adv && (state_q == S_PPS);
  assign sps_raddr_o = cnt_q[SpsAddrW-1:0];
  assign pps_raddr_o = cnt_q[PpsAddrW-1:0];

  // sequencer and output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      plan_q      <= '0;
      tok_valid_q <= 1'b0;
      tok_src_q   <= SRC_CONST;
      tok_byte_q  <= 8'h00;
      tok_last_q  <= 1'b0;
      tok_fe_q    <= 1'b0;
    end else begin
      if (adv) begin
        if (state_q != S_IDLE) begin
          tok_valid_q <= 1'b1;
          tok_last_q  <= phase_end && (state_next == S_IDLE);
          tok_fe_q    <= phase_end && (state_next == S_IDLE) && plan_q.last;
          case (state_q)
            S_SPS: begin
              tok_src_q  <= SRC_SPS;
              tok_byte_q <= 8'h00;
            end
            S_PPS: begin
              tok_src_q  <= SRC_PPS;
              tok_byte_q <= 8'h00;
            end
            S_BYTE: begin
              tok_src_q  <= SRC_CONST;
              tok_byte_q <= plan_q.byt;
            end
            S_MARK: begin
              tok_src_q  <= SRC_MARK;
              tok_byte_q <= 8'h00;
            end
            S_ZERO: begin
              tok_src_q  <= SRC_CONST;
              tok_byte_q <= SC_ZERO;
            end
            default: begin
              tok_src_q  <= SRC_CONST;
              tok_byte_q <= sc_byte;
            end
          endcase
          if (phase_end) begin
            state_q <= state_next;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + CntW'(1);
          end
        end else begin
          tok_valid_q <= 1'b0;
        end
      end
      if ((state_q == S_IDLE) && plan_valid_i) begin
        plan_q  <= plan_i;
        state_q <= state_entry;
        cnt_q   <= '0;
      end
    end
  end

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    case (tok_src_q)
      SRC_SPS: data_res_o = sps_rdata_i;
      SRC_PPS: data_res_o = pps_rdata_i;
      default: data_res_o = tok_byte_q;
    endcase
  end

  assign data_valid_o = tok_src_q != SRC_MARK;
  assign run_last_o   = tok_last_q;
  assign frame_end_o  = tok_fe_q;
  assign out_valid_o  = tok_valid_q;

endmodule

// ----- src/annexb_sps_pps_injector.sv -----
// Re-frames an H.264 Annex B byte stream. Frame bytes (op 0) are scanned for
// 4-byte start codes 00 00 00 01; every NAL unit leaves behind a fresh start
// code, and an IDR unit is preceded by start code + SPS + start code + PPS,
// taken from tables loaded with op 1 (SPS) and op 2 (PPS). With a table
// below MinTableLen bytes or overflowed, a frame yields only its end marker.
// Table beats and frame bytes that produce nothing never hold off the input.
// A frame byte that produces output beats holds off the input until its last
// beat is issued, since one sequencer walks the start codes, the table reads
// and the held zeros one beat per cycle while out_ready_i stays high. The
// first byte of an IDR unit produces up to 13 + SPS length + PPS length
// beats. A registered output beat may wait on out_ready_i while the next
// item is already taken. A frame's last byte always ends in a beat with
// frame_end_o set; with nothing else to carry, it has data_valid_o low.
module annexb_sps_pps_injector
  import asp_pkg::*;
#(
  parameter int unsigned SPS_DEPTH = 32,
  parameter int unsigned PPS_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  logic [7:0] data_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_res_o,
  output logic       data_valid_o,
  output logic       run_last_o,
  output logic       frame_end_o
);

  localparam int unsigned SpsLenW  = $clog2(SPS_DEPTH + 1);
  localparam int unsigned PpsLenW  = $clog2(PPS_DEPTH + 1);
  localparam int unsigned SpsAddrW = $clog2(SPS_DEPTH);
  localparam int unsigned PpsAddrW = $clog2(PPS_DEPTH);

  logic                in_fire;
  logic                sps_we, pps_we, sps_re, pps_re;
  logic [SpsAddrW-1:0] sps_waddr, sps_raddr;
  logic [PpsAddrW-1:0] pps_waddr, pps_raddr;
  logic [7:0]          wdata, sps_rdata, pps_rdata;
  logic [SpsLenW-1:0]  sps_len;
  logic [PpsLenW-1:0]  pps_len;
  logic                plan_valid;
  asp_plan_t           plan;

  assign in_fire = in_valid_i && in_ready_o;

  // start-code scanner and table bookkeeping
  asp_scan #(
    .SPS_DEPTH(SPS_DEPTH),
    .PPS_DEPTH(PPS_DEPTH)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .op_i        (op_i),
    .data_i      (data_i),
    .last_i      (last_i),
    .sps_we_o    (sps_we),
    .sps_waddr_o (sps_waddr),
    .pps_we_o    (pps_we),
    .pps_waddr_o (pps_waddr),
    .wdata_o     (wdata),
    .sps_len_o   (sps_len),
    .pps_len_o   (pps_len),
    .plan_valid_o(plan_valid),
    .plan_o      (plan)
  );

  // parameter-set tables
  asp_ram #(
    .Width(8),
    .Depth(SPS_DEPTH)
  ) u_sps_ram (
    .clk_i  (clk_i),
    .we_i   (sps_we),
    .waddr_i(sps_waddr),
    .wdata_i(wdata),
    .re_i   (sps_re),
    .raddr_i(sps_raddr),
    .rdata_o(sps_rdata)
  );

  asp_ram #(
    .Width(8),
    .Depth(PPS_DEPTH)
  ) u_pps_ram (
    .clk_i  (clk_i),
    .we_i   (pps_we),
    .waddr_i(pps_waddr),
    .wdata_i(wdata),
    .re_i   (pps_re),
    .raddr_i(pps_raddr),
    .rdata_o(pps_rdata)
  );

  // output sequencer
  asp_seq #(
    .SPS_DEPTH(SPS_DEPTH),
    .PPS_DEPTH(PPS_DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .plan_valid_i(plan_valid),
    .plan_i      (plan),
    .sps_len_i   (sps_len),
    .pps_len_i   (pps_len),
    .sps_rdata_i (sps_rdata),
    .pps_rdata_i (pps_rdata),
    .in_ready_o  (in_ready_o),
    .sps_re_o    (sps_re),
    .sps_raddr_o (sps_raddr),
    .pps_re_o    (pps_re),
    .pps_raddr_o (pps_raddr),
    .data_res_o  (data_res_o),
    .data_valid_o(data_valid_o),
    .run_last_o  (run_last_o),
    .frame_end_o (frame_end_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

  // table lengths never pass their store depth
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sps_len <= SpsLenW'(SPS_DEPTH)) && (pps_len <= PpsLenW'(PPS_DEPTH)))
    else $error("table length beyond depth");

  // a bare marker beat only closes a frame
  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !data_valid_o) |-> (run_last_o && frame_end_o))
    else $error("marker beat outside frame end");

  // frame end is always the last beat of its item
  a_fe_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> run_last_o)
    else $error("frame end not on last beat");

  // a frame's last byte always produces at least one beat
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (op_i == OP_FRAME) && last_i) |=> !in_ready_o)
    else $error("frame end produced no beat");

endmodule

// ----- tb/annexb_reframe_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the Annex B re-framer, predicts the output stream
// for every accepted input beat and compares each accepted output beat with
// the oldest prediction still waiting.
module annexb_reframe_checker
  import asp_pkg::*;
#(
  parameter int unsigned SpsDepth = 32,
  parameter int unsigned PpsDepth = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [1:0] op_i,
  input  logic [7:0] data_i,
  input  logic       last_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] data_res_i,
  input  logic       data_valid_i,
  input  logic       run_last_i,
  input  logic       frame_end_i,
  output int         fail_count_o,
  output int         pending_o
);

  localparam int unsigned MaxHeldZeros = StartCodeLen - 1;
  localparam int unsigned MaxReports   = 10;

  typedef struct packed {
    logic [7:0] byt;
    logic       vld;
    logic       run_end;
    logic       frm_end;
  } out_beat_t;

  // Predicted block state
  logic [7:0]  sps_tbl [SpsDepth];
  logic [7:0]  pps_tbl [PpsDepth];
  int unsigned sps_len;
  int unsigned pps_len;
  logic [1:0]  tbl_ovf;      // bit0 SPS, bit1 PPS
  logic [1:0]  tbl_loading;  // bit0 SPS, bit1 PPS
  int unsigned zero_run;     // zeros held back, may open a start code
  logic        in_unit;
  logic        hdr_wait;     // start code seen, unit's first byte not yet

  logic [7:0]  unit_bytes_q [$];   // stream bytes caused by the current beat
  out_beat_t   stream_beats_q [$]; // output beats still to arrive

  function automatic void add_byte(logic [7:0] b);
    unit_bytes_q = {unit_bytes_q, b};
  endfunction

  function automatic void add_start_code();
    repeat (StartCodeLen - 1) add_byte(SC_ZERO);
    add_byte(SC_ONE);
  endfunction

  // Works out the output beats of one accepted input beat
  function automatic void reframe_item(asp_op_e op, logic [7:0] b, logic lst);
    logic tables_ok;
    out_beat_t beat;
    case (op)
      OP_SPS: begin
        if (!tbl_loading[0]) begin
          sps_len        = 0;
          tbl_ovf[0]     = 1'b0;
          tbl_loading[0] = 1'b1;
        end
        if (sps_len < SpsDepth) begin
          sps_tbl[sps_len] = b;
          sps_len++;
        end else begin
          tbl_ovf[0] = 1'b1;
        end
        if (lst) tbl_loading[0] = 1'b0;
      end
      OP_PPS: begin
        if (!tbl_loading[1]) begin
          pps_len        = 0;
          tbl_ovf[1]     = 1'b0;
          tbl_loading[1] = 1'b1;
        end
        if (pps_len < PpsDepth) begin
          pps_tbl[pps_len] = b;
          pps_len++;
        end else begin
          tbl_ovf[1] = 1'b1;
        end
        if (lst) tbl_loading[1] = 1'b0;
      end
      OP_FRAME: begin
        tables_ok = sps_len >= MinTableLen && pps_len >= MinTableLen && tbl_ovf == 2'b00;
        unit_bytes_q.delete();
        if (zero_run == MaxHeldZeros && b == SC_ONE) begin
          // start code complete
          zero_run = 0;
          in_unit  = 1'b1;
          hdr_wait = 1'b1;
        end else if (hdr_wait) begin
          // first byte of a unit: fresh header, with tables ahead of an IDR
          hdr_wait = 1'b0;
          if ((b & NAL_TYPE_MASK) == NAL_TYPE_IDR) begin
            add_start_code();
            for (int k = 0; k < sps_len; k++) add_byte(sps_tbl[k]);
            add_start_code();
            for (int k = 0; k < pps_len; k++) add_byte(pps_tbl[k]);
          end
          add_start_code();
          if (b == SC_ZERO) zero_run = 1;
          else add_byte(b);
        end else if (b == SC_ZERO) begin
          if (zero_run < MaxHeldZeros) zero_run++;
          else if (in_unit) add_byte(SC_ZERO);
        end else begin
          if (in_unit) begin
            repeat (zero_run) add_byte(SC_ZERO);
            add_byte(b);
          end
          zero_run = 0;
        end

        // frame end flushes held zeros and returns the scan to idle
        if (lst) begin
          if (in_unit && !hdr_wait) repeat (zero_run) add_byte(SC_ZERO);
          zero_run = 0;
          in_unit  = 1'b0;
          hdr_wait = 1'b0;
        end
        if (!tables_ok) unit_bytes_q.delete();

        if (lst && unit_bytes_q.size() == 0) begin
          beat = '{SC_ZERO, 1'b0, 1'b1, 1'b1};
          stream_beats_q = {stream_beats_q, beat};
        end else begin
          foreach (unit_bytes_q[k]) begin
            beat = '{unit_bytes_q[k], 1'b1, k == unit_bytes_q.size() - 1,
                     lst && k == unit_bytes_q.size() - 1};
            stream_beats_q = {stream_beats_q, beat};
          end
        end
      end
      default: ;  // unused op, ignored
    endcase
  endfunction

  // Predict on input beats, compare on output beats
  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t got;
    out_beat_t want;
    if (!rst_ni) begin
      sps_len     = 0;
      pps_len     = 0;
      tbl_ovf     = 2'b00;
      tbl_loading = 2'b00;
      zero_run    = 0;
      in_unit     = 1'b0;
      hdr_wait    = 1'b0;
      stream_beats_q.delete();
      pending_o   = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        reframe_item(asp_op_e'(op_i), data_i, last_i);
      end
      if (out_valid_i && out_ready_i) begin
        got = '{data_res_i, data_valid_i, run_last_i, frame_end_i};
        if (stream_beats_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MaxReports) begin
            $display("unexpected output beat: data %02h valid %b run_last %b frame_end %b",
                     got.byt, got.vld, got.run_end, got.frm_end);
          end
        end else begin
          want = stream_beats_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= MaxReports) begin
              $display("beat mismatch: expected data %02h valid %b run_last %b frame_end %b",
                       want.byt, want.vld, want.run_end, want.frm_end);
              $display("               got      data %02h valid %b run_last %b frame_end %b",
                       got.byt, got.vld, got.run_end, got.frm_end);
            end
          end
        end
      end
      pending_o = stream_beats_q.size();
    end
  end

endmodule

// ----- tb/annexb_sps_pps_injector_test.sv -----
`timescale 1ns / 1ps

module annexb_sps_pps_injector_test;
  import asp_pkg::*;

  localparam int unsigned SpsDepth    = 32;
  localparam int unsigned PpsDepth    = 16;
  localparam int unsigned RandomItems = 430;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned ResetCycles = 12;

  typedef logic [7:0] byte_q_t [$];

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_ready;
  asp_op_e    op_val;
  logic [7:0] data_val;
  logic       last_val;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] data_res;
  logic       data_valid;
  logic       run_last;
  logic       frame_end;

  int src_idle_pct;
  int dst_idle_pct;
  int items_sent;
  int fail_count;
  int pending;

  annexb_sps_pps_injector #(
    .SPS_DEPTH(SpsDepth),
    .PPS_DEPTH(PpsDepth)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .op_i        (op_val),
    .data_i      (data_val),
    .last_i      (last_val),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .data_res_o  (data_res),
    .data_valid_o(data_valid),
    .run_last_o  (run_last),
    .frame_end_o (frame_end)
  );

  annexb_reframe_checker #(
    .SpsDepth(SpsDepth),
    .PpsDepth(PpsDepth)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .op_i        (op_val),
    .data_i      (data_val),
    .last_i      (last_val),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .data_res_i  (data_res),
    .data_valid_i(data_valid),
    .run_last_i  (run_last),
    .frame_end_i (frame_end),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // 20 ns clock
  always #10 clk_i = ~clk_i;

  // Receiver stalls at random
  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= dst_idle_pct);
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // One input beat; returns at the falling edge after acceptance
  task automatic send_beat(asp_op_e op, logic [7:0] b, logic lst);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    op_val   <= op;
    data_val <= b;
    last_val <= lst;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    if (op != OP_NONE) items_sent++;
  endtask

  task automatic load_table(asp_op_e op, int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_beat(op, 8'($urandom_range(255)), i == len - 1);
    end
  endtask

  // Table length: mostly valid, sometimes short, full or overflowing
  function automatic int unsigned pick_len(int unsigned depth);
    int r;
    r = $urandom_range(99);
    if (r < 6) return $urandom_range(1, MinTableLen - 1);
    if (r < 12) return depth + $urandom_range(1, 3);
    if (r < 22) return depth;
    return $urandom_range(MinTableLen, MinTableLen + 6);
  endfunction

  // Frame bytes, optionally with ignored beats and PPS reloads mixed in
  task automatic send_frame(byte_q_t bytes, bit noisy);
    foreach (bytes[i]) begin
      if (noisy && $urandom_range(99) < 3) begin
        send_beat(OP_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      if (noisy && $urandom_range(99) < 2) begin
        load_table(OP_PPS, $urandom_range(MinTableLen, MinTableLen + 4));
      end
      send_beat(OP_FRAME, bytes[i], i == bytes.size() - 1);
    end
  endtask

  // Mostly well-formed frames with random content, some broken start codes
  task automatic random_frame(bit force_idr);
    byte_q_t bytes;
    int unsigned units;
    int r;
    repeat ($urandom_range(2)) bytes = {bytes, 8'($urandom_range(255))};
    units = $urandom_range(force_idr, 3);
    for (int unsigned u = 0; u < units; u++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        // three-byte code, not recognized
        bytes = {bytes, SC_ZERO, SC_ZERO, SC_ONE};
      end else if (r < 14) begin
        // extra leading zero
        bytes = {bytes, SC_ZERO, SC_ZERO, SC_ZERO, SC_ZERO, SC_ONE};
      end else if (r < 20) begin
        bytes = {bytes, SC_ZERO, SC_ZERO, SC_ZERO, 8'($urandom_range(255))};
      end else begin
        bytes = {bytes, SC_ZERO, SC_ZERO, SC_ZERO, SC_ONE};
      end
      // frame may end right on a start code
      if (u == units - 1 && !force_idr && $urandom_range(9) == 0) break;
      r = $urandom_range(99);
      if (r < 30 || (force_idr && u == 0)) begin
        bytes = {bytes, {3'($urandom_range(7)), NAL_TYPE_IDR[4:0]}};
      end else if (r < 38) begin
        bytes = {bytes, SC_ZERO};
      end else begin
        bytes = {bytes, 8'($urandom_range(255))};
      end
      repeat ($urandom_range(6)) begin
        bytes = {bytes, (($urandom_range(99) < 30) ? SC_ZERO : 8'($urandom_range(255)))};
      end
    end
    if (bytes.size() == 0) bytes = {bytes, 8'($urandom_range(255))};
    send_frame(bytes, 1'b1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Stimulus and verdict
  initial begin
    int unsigned base;
    int unsigned frame_idx;
    int phase;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    op_val       = OP_FRAME;
    data_val     = 8'h00;
    last_val     = 1'b0;
    items_sent   = 0;
    src_idle_pct = 10;
    dst_idle_pct = 60;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // IDR frame with tables never loaded: only the frame-end marker
    send_frame('{8'h00, 8'h00, 8'h00, 8'h01, 8'h65}, 1'b0);
    // smallest legal tables
    load_table(OP_SPS, MinTableLen);
    load_table(OP_PPS, MinTableLen);
    send_beat(OP_NONE, 8'hFF, 1'b1);
    // leading junk, IDR unit, zero run inside a unit, empty unit, held zeros at end
    send_frame('{8'h7E, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'h00, 8'h00,
                 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
                 8'h01, 8'h41, 8'h00, 8'h00}, 1'b0);
    // start code at frame end
    send_frame('{8'h00, 8'h00, 8'h00, 8'h01}, 1'b0);
    wait_drained();

    base      = items_sent;
    frame_idx = 0;
    phase     = 0;
    while (items_sent - base < RandomItems) begin
      if (phase == 0 && items_sent - base >= RandomItems / 3) begin
        wait_drained();
        src_idle_pct = 60;
        dst_idle_pct = 10;
        phase        = 1;
      end else if (phase == 1 && items_sent - base >= 2 * RandomItems / 3) begin
        wait_drained();
        src_idle_pct = 0;
        dst_idle_pct = 0;
        phase        = 2;
      end
      // table extremes first, then random reloads
      case (frame_idx)
        0: begin
          load_table(OP_SPS, SpsDepth);
          load_table(OP_PPS, PpsDepth);
        end
        1: load_table(OP_SPS, SpsDepth + $urandom_range(1, 3));
        2: load_table(OP_SPS, MinTableLen - 1);
        3: begin
          load_table(OP_SPS, MinTableLen);
          load_table(OP_PPS, PpsDepth + 1);
        end
        4: load_table(OP_PPS, $urandom_range(1, MinTableLen - 1));
        5: load_table(OP_PPS, MinTableLen);
        default: begin
          if ($urandom_range(99) < 12) load_table(OP_SPS, pick_len(SpsDepth));
          if ($urandom_range(99) < 12) load_table(OP_PPS, pick_len(PpsDepth));
        end
      endcase
      random_frame(frame_idx == 0);
      frame_idx++;
    end

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
